### hw/rtl/bfle_pkg.sv
// Shared constants and types for the line box filter with edge replication.
// Used by bfle_front, bfle_back and box_filter_line_replicate_edge; no dependencies.
package bfle_pkg;

    localparam int PIX_W       = 8;
    localparam int RAD_W       = 4;
    localparam int MAX_RADIUS  = 15;
    localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = $clog2(255 * STORE_DEPTH + 1);
    localparam int SEEN_W      = $clog2(MAX_RADIUS + 2);
    localparam int CMP_W       = SEEN_W + 1;
    localparam int DIV_CNT_W   = $clog2(PIX_W);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t pixel;
        logic line_end;
        logic line_start;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESUM,
        ST_TAIL,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

### hw/rtl/box_filter_line_replicate_edge.sv
// Top level of the horizontal box filter with edge replication.
// Instantiates bfle_front and bfle_back; holds the radius register. Depends on bfle_pkg.
//
// Pixels of a line enter as beats with line_end on the last one; result i is the floor
// of the mean of pixels i-r..i+r, with the first and last pixels replicated past the
// line ends, and each line yields as many results as pixels. Each result comes from a
// pass that shifts the window and updates the running sum, runs the bit-serial divide
// by 2r+1 (one quotient bit per cycle), and loads the result register, which waits
// while an earlier result is still held there by a low res_ready. An input with
// line_end then makes r trailing shifts of the last pixel, each one that yields a
// result passing through the same divide and load. After a write of the radius
// through cfg_we the back end re-adds the window before the next pixel.
// A four-beat queue decouples input acceptance from this work.
module box_filter_line_replicate_edge
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bfle_pkg::RAD_W-1:0]   cfg_wdata,
    input  logic                         pix_valid,
    output logic                         pix_ready,
    input  bfle_pkg::pix_t               pixel,
    input  logic                         line_end,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bfle_pkg::pix_t               filtered,
    output logic                         run_end,
    output logic                         line_done
);

    logic [bfle_pkg::RAD_W-1:0] radius_reg;
    logic [bfle_pkg::RAD_W-1:0] radius_next;
    logic                       item_valid;
    logic                       item_pop;
    bfle_pkg::item_t            item;

    assign radius_next = cfg_we ? cfg_wdata : radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= bfle_pkg::RADIUS_RESET;
        end
        else
        begin
            radius_reg <= radius_next;
        end
    end

    bfle_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pixel      (pixel),
        .line_end   (line_end),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item)
    );

    bfle_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .radius     (radius_reg),
        .cfg_we     (cfg_we),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .filtered   (filtered),
        .run_end    (run_end),
        .line_done  (line_done)
    );

endmodule

### hw/rtl/bfle_front.sv
// Input side of the line box filter: accepts pixel beats, marks line starts
// and holds them in a short queue for the back end. Depends on bfle_pkg.
module bfle_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    output logic            pix_ready,
    input  bfle_pkg::pix_t  pixel,
    input  logic            line_end,
    output logic            item_valid,
    input  logic            item_pop,
    output bfle_pkg::item_t item
);

    bfle_pkg::item_t                  queue_reg [bfle_pkg::QDEPTH];
    logic [bfle_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [bfle_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [bfle_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [bfle_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [bfle_pkg::QCNT_W-1:0]      count_reg;
    logic [bfle_pkg::QCNT_W-1:0]      count_next;
    logic                             line_start_reg;
    logic                             line_start_next;
    logic                             push;
    logic                             pop;

    assign pix_ready  = (count_reg < bfle_pkg::QCNT_W'(bfle_pkg::QDEPTH));
    assign push       = pix_valid && pix_ready;
    assign item_valid = (count_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        count_next      = count_reg;
        line_start_next = line_start_reg;
        if (push)
        begin
            wr_ptr_next     = wr_ptr_reg + 1'b1;
            line_start_next = line_end;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            line_start_reg <= 1'b1;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            line_start_reg <= line_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{pixel: pixel, line_end: line_end,
                                       line_start: line_start_reg};
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bfle_pkg::QCNT_W'(bfle_pkg::QDEPTH))
        else $error("queue count above depth");

    a_line_start_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
        push && line_end |=> line_start_reg)
        else $error("line start not marked after line end");
`endif

endmodule

### hw/rtl/bfle_back.sv
// Execution side of the line box filter: window shift line, running sum,
// serial divider and result register. Depends on bfle_pkg.
module bfle_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bfle_pkg::RAD_W-1:0]   radius,
    input  logic                         cfg_we,
    input  logic                         item_valid,
    output logic                         item_pop,
    input  bfle_pkg::item_t              item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bfle_pkg::pix_t               filtered,
    output logic                         run_end,
    output logic                         line_done
);

    localparam logic [bfle_pkg::SEEN_W-1:0] SEEN_MAX =
        bfle_pkg::SEEN_W'(bfle_pkg::MAX_RADIUS + 1);
    localparam logic [bfle_pkg::DIV_CNT_W-1:0] DIV_LAST =
        bfle_pkg::DIV_CNT_W'(bfle_pkg::PIX_W - 1);

    bfle_pkg::back_state_t                state_reg;
    bfle_pkg::back_state_t                state_next;
    bfle_pkg::pix_t                       store_reg [bfle_pkg::STORE_DEPTH];
    bfle_pkg::pix_t                       store_next [bfle_pkg::STORE_DEPTH];
    logic [bfle_pkg::SUM_W-1:0]           sum_reg;
    logic [bfle_pkg::SUM_W-1:0]           sum_next;
    logic [bfle_pkg::SEEN_W-1:0]          seen_reg;
    logic [bfle_pkg::SEEN_W-1:0]          seen_next;
    logic [bfle_pkg::SEEN_W-1:0]          seen_new;
    logic                                 dirty_reg;
    logic                                 dirty_next;
    logic [bfle_pkg::IDX_W-1:0]           k_reg;
    logic [bfle_pkg::IDX_W-1:0]           k_next;
    logic [bfle_pkg::RAD_W-1:0]           t_reg;
    logic [bfle_pkg::RAD_W-1:0]           t_next;
    logic [bfle_pkg::RAD_W-1:0]           t_new;
    bfle_pkg::pix_t                       pix_reg;
    bfle_pkg::pix_t                       pix_next;
    logic                                 last_reg;
    logic                                 last_next;
    logic [bfle_pkg::LEN_W-1:0]           rem_reg;
    logic [bfle_pkg::LEN_W-1:0]           rem_next;
    bfle_pkg::pix_t                       dlo_reg;
    bfle_pkg::pix_t                       dlo_next;
    logic [bfle_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [bfle_pkg::DIV_CNT_W-1:0]       cnt_next;
    logic                                 res_valid_reg;
    logic                                 res_valid_next;
    bfle_pkg::pix_t                       filtered_reg;
    bfle_pkg::pix_t                       filtered_next;
    logic                                 run_end_reg;
    logic                                 run_end_next;
    logic                                 line_done_reg;
    logic                                 line_done_next;

    logic [bfle_pkg::RAD_W-1:0]           r_eff;
    logic [bfle_pkg::LEN_W-1:0]           win_len;
    logic [bfle_pkg::IDX_W-1:0]           tail_idx;
    logic [bfle_pkg::IDX_W-1:0]           rd_idx;
    bfle_pkg::pix_t                       leave_pix;
    logic [bfle_pkg::LEN_W:0]             trial;
    logic                                 is_final;

    assign r_eff    = (int'(radius) > bfle_pkg::MAX_RADIUS) ?
                      bfle_pkg::RAD_W'(bfle_pkg::MAX_RADIUS) : radius;
    assign win_len  = bfle_pkg::LEN_W'({r_eff, 1'b1});
    assign tail_idx = bfle_pkg::IDX_W'({r_eff, 1'b0});
    assign rd_idx   = (state_reg == bfle_pkg::ST_RESUM) ? k_reg : tail_idx;
    assign leave_pix = store_reg[rd_idx];
    assign trial    = {rem_reg, dlo_reg[bfle_pkg::PIX_W-1]};
    assign is_final = (t_reg == r_eff);

    always_comb
    begin
        state_next     = state_reg;
        store_next     = store_reg;
        sum_next       = sum_reg;
        seen_next      = seen_reg;
        seen_new       = seen_reg;
        dirty_next     = dirty_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        t_new          = t_reg + 1'b1;
        pix_next       = pix_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        dlo_next       = dlo_reg;
        cnt_next       = cnt_reg;
        filtered_next  = filtered_reg;
        run_end_next   = run_end_reg;
        line_done_next = line_done_reg;
        res_valid_next = res_valid_reg && !res_ready;
        item_pop       = 1'b0;

        case (state_reg)
            bfle_pkg::ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    sum_next   = '0;
                    k_next     = '0;
                    state_next = bfle_pkg::ST_RESUM;
                end
                else if (item_valid)
                begin
                    item_pop  = 1'b1;
                    pix_next  = item.pixel;
                    last_next = item.line_end;
                    t_next    = '0;
                    if (item.line_start)
                    begin
                        for (int i = 0; i < bfle_pkg::STORE_DEPTH; i++)
                        begin
                            store_next[i] = item.pixel;
                        end
                        sum_next = bfle_pkg::SUM_W'(item.pixel) *
                                   bfle_pkg::SUM_W'(win_len);
                        seen_new = bfle_pkg::SEEN_W'(1);
                    end
                    else
                    begin
                        store_next[0] = item.pixel;
                        for (int i = 1; i < bfle_pkg::STORE_DEPTH; i++)
                        begin
                            store_next[i] = store_reg[i-1];
                        end
                        sum_next = sum_reg + bfle_pkg::SUM_W'(item.pixel) -
                                   bfle_pkg::SUM_W'(leave_pix);
                        seen_new = (seen_reg < SEEN_MAX) ? seen_reg + 1'b1 : seen_reg;
                    end
                    seen_next = seen_new;
                    if (seen_new > bfle_pkg::SEEN_W'(r_eff))
                    begin
                        rem_next   = bfle_pkg::LEN_W'(sum_next >> bfle_pkg::PIX_W);
                        dlo_next   = sum_next[bfle_pkg::PIX_W-1:0];
                        cnt_next   = '0;
                        state_next = bfle_pkg::ST_DIV;
                    end
                    else if (item.line_end)
                    begin
                        state_next = bfle_pkg::ST_TAIL;
                    end
                end
            end

            bfle_pkg::ST_RESUM:
            begin
                if (cfg_we)
                begin
                    sum_next = '0;
                    k_next   = '0;
                end
                else
                begin
                    sum_next = sum_reg + bfle_pkg::SUM_W'(leave_pix);
                    if (k_reg == tail_idx)
                    begin
                        dirty_next = 1'b0;
                        state_next = bfle_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end

            bfle_pkg::ST_TAIL:
            begin
                store_next[0] = pix_reg;
                for (int i = 1; i < bfle_pkg::STORE_DEPTH; i++)
                begin
                    store_next[i] = store_reg[i-1];
                end
                sum_next = sum_reg + bfle_pkg::SUM_W'(pix_reg) -
                           bfle_pkg::SUM_W'(leave_pix);
                t_next = t_new;
                if (bfle_pkg::CMP_W'(t_new) + bfle_pkg::CMP_W'(seen_reg) >
                    bfle_pkg::CMP_W'(r_eff))
                begin
                    rem_next   = bfle_pkg::LEN_W'(sum_next >> bfle_pkg::PIX_W);
                    dlo_next   = sum_next[bfle_pkg::PIX_W-1:0];
                    cnt_next   = '0;
                    state_next = bfle_pkg::ST_DIV;
                end
                else if (t_new >= r_eff)
                begin
                    seen_next  = '0;
                    state_next = bfle_pkg::ST_IDLE;
                end
            end

            bfle_pkg::ST_DIV:
            begin
                if (trial >= {1'b0, win_len})
                begin
                    rem_next = bfle_pkg::LEN_W'(trial - {1'b0, win_len});
                    dlo_next = {dlo_reg[bfle_pkg::PIX_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[bfle_pkg::LEN_W-1:0];
                    dlo_next = {dlo_reg[bfle_pkg::PIX_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = bfle_pkg::ST_OUT;
                end
            end

            bfle_pkg::ST_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    filtered_next  = dlo_reg;
                    run_end_next   = !last_reg || is_final;
                    line_done_next = last_reg && is_final;
                    if (last_reg && !is_final)
                    begin
                        state_next = bfle_pkg::ST_TAIL;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            seen_next = '0;
                        end
                        state_next = bfle_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = bfle_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfle_pkg::ST_IDLE;
            seen_reg      <= '0;
            dirty_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            dirty_reg     <= dirty_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg     <= store_next;
        sum_reg       <= sum_next;
        k_reg         <= k_next;
        t_reg         <= t_next;
        pix_reg       <= pix_next;
        last_reg      <= last_next;
        rem_reg       <= rem_next;
        dlo_reg       <= dlo_next;
        cnt_reg       <= cnt_next;
        filtered_reg  <= filtered_next;
        run_end_reg   <= run_end_next;
        line_done_reg <= line_done_next;
    end

    assign res_valid = res_valid_reg;
    assign filtered  = filtered_reg;
    assign run_end   = run_end_reg;
    assign line_done = line_done_reg;

`ifndef NO_ASSERTIONS
    a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (state_reg == bfle_pkg::ST_IDLE && !dirty_reg))
        else $error("item taken while back end busy");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfle_pkg::ST_DIV && cnt_reg == DIV_LAST |=>
        state_reg == bfle_pkg::ST_OUT)
        else $error("division did not finish after eight steps");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_MAX)
        else $error("pixel count above saturation");

    a_tail_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bfle_pkg::ST_TAIL |-> last_reg)
        else $error("edge run outside a line end");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for box_filter_line_replicate_edge: lines of pixels go in,
// window means are predicted per accepted beat and checked against every result beat.
// Depends on bfle_pkg and the box_filter_line_replicate_edge RTL.
module tb;

    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        bfle_pkg::pix_t pixel;
        logic line_end;
    } pixel_beat_t;

    typedef struct packed {
        bfle_pkg::pix_t filtered;
        logic run_end;
        logic line_done;
    } mean_result_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [bfle_pkg::RAD_W-1:0] cfg_wdata = '0;
    logic                       pix_valid = 1'b0;
    logic                       pix_ready;
    bfle_pkg::pix_t             pixel     = '0;
    logic                       line_end  = 1'b0;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    bfle_pkg::pix_t             filtered;
    logic                       run_end;
    logic                       line_done;

    pixel_beat_t  pending_pixels[$];
    mean_result_t window_means_q[$];
    pixel_beat_t  next_beat;
    mean_result_t got_mean;
    mean_result_t want_mean;

    bfle_pkg::pix_t             window_px [bfle_pkg::STORE_DEPTH] = '{default: '0};
    int unsigned                line_count   = 0;
    logic [bfle_pkg::RAD_W-1:0] radius_model = bfle_pkg::RADIUS_RESET;

    int gap_pct    = 30;
    int stall_pct  = 30;
    int gap_left   = 0;
    int stall_left = 0;
    int errors     = 0;

    box_filter_line_replicate_edge DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pixel     (pixel),
        .line_end  (line_end),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .filtered  (filtered),
        .run_end   (run_end),
        .line_done (line_done)
    );

    always #1 clk = ~clk;

    function automatic int pick_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
        begin
            return $urandom_range(0, 2);
        end
        if (sel < 95)
        begin
            return $urandom_range(3, 9);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic bfle_pkg::pix_t rand_pixel();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            return '0;
        end
        if (sel < 30)
        begin
            return '1;
        end
        return bfle_pkg::pix_t'($urandom_range(0, 255));
    endfunction

    function automatic bfle_pkg::pix_t window_mean(int unsigned r);
        int unsigned total;
        total = 0;
        for (int i = 0; i < 2 * r + 1; i++)
        begin
            total += window_px[i];
        end
        return bfle_pkg::pix_t'(total / (2 * r + 1));
    endfunction

    task automatic shift_window(bfle_pkg::pix_t p);
        for (int i = bfle_pkg::STORE_DEPTH - 1; i > 0; i--)
        begin
            window_px[i] = window_px[i - 1];
        end
        window_px[0] = p;
    endtask

    task automatic predict_beat(bfle_pkg::pix_t p, logic last);
        int unsigned  r;
        int           produced;
        mean_result_t tail;
        r = (radius_model > bfle_pkg::MAX_RADIUS) ? bfle_pkg::MAX_RADIUS : radius_model;
        produced = 0;
        if (line_count == 0)
        begin
            foreach (window_px[i])
            begin
                window_px[i] = p;
            end
        end
        else
        begin
            shift_window(p);
        end
        if (line_count < bfle_pkg::MAX_RADIUS + 1)
        begin
            line_count++;
        end
        if (line_count >= r + 1)
        begin
            window_means_q.push_back(mean_result_t'({window_mean(r), 2'b00}));
            produced++;
        end
        if (last)
        begin
            for (int unsigned t = 1; t <= r; t++)
            begin
                shift_window(p);
                if (t + line_count >= r + 1)
                begin
                    window_means_q.push_back(mean_result_t'({window_mean(r), 2'b00}));
                    produced++;
                end
            end
            line_count = 0;
        end
        if (produced > 0)
        begin
            tail = window_means_q.pop_back();
            tail.run_end = 1'b1;
            tail.line_done = last;
            window_means_q.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pixel <= '0;
            line_end <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                predict_beat(pixel, line_end);
            end
            if (!pix_valid || pix_ready)
            begin
                if (gap_left != 0 || pending_pixels.size() == 0)
                begin
                    pix_valid <= 1'b0;
                    if (gap_left != 0)
                    begin
                        gap_left <= gap_left - 1;
                    end
                end
                else
                begin
                    next_beat = pending_pixels.pop_front();
                    pix_valid <= 1'b1;
                    pixel <= next_beat.pixel;
                    line_end <= next_beat.line_end;
                    gap_left <= ($urandom_range(0, 99) < gap_pct) ? pick_len() : 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got_mean = mean_result_t'({filtered, run_end, line_done});
                if (window_means_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, filtered %0d run_end %0b line_done %0b",
                             $time, got_mean.filtered, got_mean.run_end, got_mean.line_done);
                    errors++;
                end
                else
                begin
                    want_mean = window_means_q.pop_front();
                    if (got_mean.filtered !== want_mean.filtered)
                    begin
                        $display("%0t: filtered expected %0d actual %0d",
                                 $time, want_mean.filtered, got_mean.filtered);
                        errors++;
                    end
                    if (got_mean.run_end !== want_mean.run_end)
                    begin
                        $display("%0t: run_end expected %0b actual %0b",
                                 $time, want_mean.run_end, got_mean.run_end);
                        errors++;
                    end
                    if (got_mean.line_done !== want_mean.line_done)
                    begin
                        $display("%0t: line_done expected %0b actual %0b",
                                 $time, want_mean.line_done, got_mean.line_done);
                        errors++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                res_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                res_ready <= 1'b0;
                stall_left <= pick_len();
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic add_beat(bfle_pkg::pix_t p, logic last);
        pending_pixels.push_back(pixel_beat_t'({p, last}));
    endtask

    task automatic add_random_line(int len);
        for (int i = 0; i < len; i++)
        begin
            add_beat(rand_pixel(), i == len - 1);
        end
    endtask

    // A beat that yields no mean may still be in the back end when the last mean arrives.
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (pending_pixels.size() != 0 || pix_valid || window_means_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_radius(logic [bfle_pkg::RAD_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        radius_model = value;
    endtask

    initial
    begin : stimulus
        int r;
        int phase_items;
        int len;
        int sel;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_beat(8'd255, 1'b0);
        add_beat(8'd0, 1'b0);
        add_beat(8'd255, 1'b0);
        add_beat(8'd128, 1'b1);
        add_beat(8'd255, 1'b1);
        wait_idle();
        set_radius(4'd0);
        add_beat(8'd0, 1'b0);
        add_beat(8'd255, 1'b1);
        wait_idle();
        set_radius(4'd15);
        add_beat(8'd1, 1'b0);
        add_beat(8'd254, 1'b0);
        add_beat(8'd255, 1'b1);
        add_beat(8'd255, 1'b1);
        wait_idle();
        set_radius(4'd2);
        add_beat(8'd255, 1'b0);
        add_beat(8'd255, 1'b0);
        add_beat(8'd0, 1'b0);
        add_beat(8'd0, 1'b0);
        add_beat(8'd128, 1'b0);
        wait_idle();
        // The radius changes in the middle of a line.
        set_radius(4'd4);
        add_beat(8'd7, 1'b0);
        add_beat(8'd200, 1'b0);
        add_beat(8'd255, 1'b1);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            r = (p == 0) ? 0 : (p == 1) ? 15 : (p == 2) ? 1 : $urandom_range(0, 15);
            gap_pct = (p % 4 == 2) ? 0 : $urandom_range(10, 60);
            stall_pct = (p % 4 == 3) ? 0 : $urandom_range(10, 60);
            set_radius(r[bfle_pkg::RAD_W-1:0]);
            phase_items = 0;
            while (phase_items < 33)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 25)
                begin
                    len = $urandom_range(1, r + 1);
                end
                else if (sel < 85)
                begin
                    len = $urandom_range(1, 40);
                end
                else
                begin
                    len = $urandom_range(41, 70);
                end
                if (len > 33 - phase_items)
                begin
                    len = 33 - phase_items;
                end
                add_random_line(len);
                phase_items += len;
            end
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #10000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
